@@ design/assd_pkg.sv @@
// shared types, constants and digit helpers for the averaged sample display driver
// no dependencies
package assd_pkg;

  localparam int WORD_W = 16;
  localparam int BIT_CNT_W = 4;

  typedef enum logic [1:0] {
    POS_ONES     = 2'd0,
    POS_TENS     = 2'd1,
    POS_HUNDREDS = 2'd2
  } digit_pos_t;

  // one refresh tick as handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        pos;
  } tick_t;

  // active-low segment patterns for decimal digits
  localparam logic [7:0] SEG_PATTERN [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [7:0] SEL_ONES     = 8'hF8;
  localparam logic [7:0] SEL_TENS     = 8'hF4;
  localparam logic [7:0] SEL_HUNDREDS = 8'hF2;

  // decimal digit of an 8-bit value; divides by 10 and 100 via reciprocal multiply
  function automatic logic [3:0] digit_of(logic [7:0] v, logic [1:0] pos);
    logic [15:0] p10;
    logic [13:0] p100;
    logic [4:0]  q10;
    logic [1:0]  q100;
    logic [7:0]  ones;
    logic [7:0]  tens;
    logic [3:0]  d;
    p10  = 16'(v) * 16'd205;
    p100 = 14'(v) * 14'd41;
    q10  = p10[15:11];
    q100 = p100[13:12];
    ones = v - 8'(8'(q10) * 8'd10);
    tens = 8'(q10) - 8'(8'(q100) * 8'd10);
    case (pos)
      POS_TENS:     d = tens[3:0];
      POS_HUNDREDS: d = {2'b00, q100};
      default:      d = ones[3:0];
    endcase
    return d;
  endfunction

  function automatic logic [7:0] select_of(logic [1:0] pos);
    logic [7:0] s;
    case (pos)
      POS_TENS:     s = SEL_TENS;
      POS_HUNDREDS: s = SEL_HUNDREDS;
      default:      s = SEL_ONES;
    endcase
    return s;
  endfunction

endpackage

@@ design/assd_in_if.sv @@
// input channel: samples and refresh ticks with valid/ready
// no dependencies
interface assd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink (input valid, mode, sample, output ready);
endinterface

@@ design/assd_out_if.sv @@
// output channel: one serial bit per transaction with valid/ready
// no dependencies
interface assd_out_if;
  logic       valid;
  logic       ready;
  logic       serial_bit;
  logic       latch_after;
  logic [1:0] digit_position;

  modport source (output valid, serial_bit, latch_after, digit_position, input ready);
  modport sink (input valid, serial_bit, latch_after, digit_position, output ready);
endinterface

@@ design/assd_front.sv @@
// front end: accumulates samples, keeps the shown value, turns ticks into 16-bit words
// depends on assd_pkg and assd_in_if
module assd_front #(
  parameter int SAMPLES_AVERAGED = 4
) (
  input  logic              clk,
  input  logic              rst,
  assd_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output assd_pkg::tick_t   push_data
);

  localparam int CNT_W   = $clog2(SAMPLES_AVERAGED);
  localparam int SUM_W   = 8 + CNT_W;
  localparam int SHIFT   = SUM_W + 5;
  localparam int PROD_W  = SUM_W + SHIFT;
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'((2**SHIFT + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_AVERAGED - 1);

  logic [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [7:0]        shown_value;
  logic [1:0]        next_digit;

  logic              accept;
  logic [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0] avg_prod;
  logic [3:0]        digit;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sum_next    = sample_sum + SUM_W'(in_ch.sample);
  // floor(sum / n) as multiply by ceil(2^shift / n)
  assign avg_prod    = PROD_W'(sum_next) * PROD_W'(RECIP);

  assign digit          = assd_pkg::digit_of(shown_value, next_digit);
  assign push           = accept && in_ch.mode;
  assign push_data.word = {assd_pkg::SEG_PATTERN[digit], assd_pkg::select_of(next_digit)};
  assign push_data.pos  = next_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      shown_value  <= '0;
      next_digit   <= assd_pkg::POS_ONES;
    end else if (accept) begin
      if (!in_ch.mode) begin
        if (sample_count == LAST_CNT) begin
          shown_value  <= avg_prod[SHIFT +: 8];
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= sample_count + 1'b1;
        end
      end else begin
        next_digit <= (next_digit == assd_pkg::POS_HUNDREDS) ? assd_pkg::POS_ONES
                                                              : next_digit + 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_CNT) else $error("sample count past group size");
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    next_digit != 2'd3) else $error("digit pointer out of range");

endmodule

@@ design/assd_queue.sv @@
// two-entry queue of refresh words between front and back
// depends on assd_pkg
module assd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  assd_pkg::tick_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output assd_pkg::tick_t pop_data
);

  assd_pkg::tick_t entry [2];
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;

  assign full     = count == 2'd2;
  assign avail    = count != 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail) else $error("queue underflow");

endmodule

@@ design/assd_back.sv @@
// back end: shifts each refresh word out msb first, one bit per transaction
// depends on assd_pkg and assd_out_if
module assd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  assd_pkg::tick_t pop_data,
  output logic            pop,
  assd_out_if.source      out_ch
);

  logic                             busy;
  logic [assd_pkg::WORD_W-1:0]      shreg;
  logic [assd_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [1:0]                       pos;
  logic                             fire;
  logic                             last;

  assign fire = out_ch.valid && out_ch.ready;
  assign last = bit_cnt == '1;
  // load the next word when idle or as the last bit leaves
  assign pop  = avail && (!busy || (fire && last));

  assign out_ch.valid          = busy;
  assign out_ch.serial_bit     = shreg[assd_pkg::WORD_W-1];
  assign out_ch.latch_after    = last;
  assign out_ch.digit_position = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (pop) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= pop_data.word;
      pos   <= pop_data.pos;
    end else if (fire) begin
      shreg <= {shreg[assd_pkg::WORD_W-2:0], 1'b0};
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    fire && !last |=> out_ch.valid && bit_cnt == $past(bit_cnt) + 1'b1)
    else $error("serial run broken before sixteenth bit");

endmodule

@@ design/averaged_sample_seven_segment_driver.sv @@
// Averaged sample display driver. A sample transaction (mode 0) gives no output;
// every SAMPLES_AVERAGED samples the floor average becomes the shown value. A refresh
// tick (mode 1) gives 16 output transactions, one serial bit per cycle while out_ch
// ready is high, segment byte then digit-select byte, msb first, with latch_after on
// the sixteenth. The serializer sets the pace, with ticks shifted out back to back and a
// two-tick queue ahead of it; inputs stall only when that queue is full. Ticks cycle
// through ones, tens, hundreds. Depends on assd_pkg, assd_in_if, assd_out_if,
// assd_front, assd_queue, assd_back.
module averaged_sample_seven_segment_driver #(
  parameter int SAMPLES_AVERAGED = 4
) (
  input  logic        clk,
  input  logic        rst,
  assd_in_if.sink     in_ch,
  assd_out_if.source  out_ch
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_avail;
  assd_pkg::tick_t push_data;
  assd_pkg::tick_t pop_data;

  assd_front #(
    .SAMPLES_AVERAGED (SAMPLES_AVERAGED)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  assd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .avail     (q_avail),
    .pop_data  (pop_data)
  );

  assd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (q_avail),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ tb/averaged_sample_seven_segment_driver_tb.sv @@
// self-checking bench for the averaged sample seven-segment driver: directed table, then
// shaped random sample groups and refresh ticks under three idling patterns
// depends on assd_pkg, assd_in_if, assd_out_if and the driver rtl
module averaged_sample_seven_segment_driver_tb;

  localparam int GROUP_SIZE = 4;
  localparam int BITS_PER_TICK = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 50;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // active-low segments, digits 0..9
  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic       serial_bit;
    logic       latch_after;
    logic [1:0] digit_position;
  } serial_beat_t;

  // mode, sample, whether the shift word is typed in, the word
  typedef struct packed {
    logic        mode;
    logic [7:0]  sample;
    logic        typed;
    logic [15:0] word;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // display after reset reads 000
    '{MODE_TICK,   8'h00, 1'b1, 16'hC0F8},
    '{MODE_TICK,   8'h00, 1'b1, 16'hC0F4},
    '{MODE_TICK,   8'h00, 1'b1, 16'hC0F2},
    // full-scale group averages to 255
    '{MODE_SAMPLE, 8'hFF, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'hFF, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'hFF, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'hFF, 1'b0, 16'h0000},
    // sample field on a tick is ignored
    '{MODE_TICK,   8'hFF, 1'b1, 16'h92F8},
    '{MODE_TICK,   8'h00, 1'b1, 16'h92F4},
    '{MODE_TICK,   8'h00, 1'b1, 16'hA4F2},
    // floor of 3/4 is zero
    '{MODE_SAMPLE, 8'h00, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h00, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h00, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h03, 1'b0, 16'h0000},
    '{MODE_TICK,   8'h00, 1'b1, 16'hC0F8},
    '{MODE_SAMPLE, 8'h80, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h80, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h81, 1'b0, 16'h0000},
    '{MODE_SAMPLE, 8'h7F, 1'b0, 16'h0000},
    '{MODE_TICK,   8'h55, 1'b0, 16'h0000},
    '{MODE_TICK,   8'hAA, 1'b0, 16'h0000},
    '{MODE_TICK,   8'h00, 1'b0, 16'h0000},
    // partial group leaves the display alone
    '{MODE_SAMPLE, 8'h09, 1'b0, 16'h0000},
    '{MODE_TICK,   8'h00, 1'b0, 16'h0000},
    '{MODE_TICK,   8'h00, 1'b0, 16'h0000}
  };

  logic clk;
  logic rst;

  assd_in_if  in_ch ();
  assd_out_if out_ch ();

  averaged_sample_seven_segment_driver #(.SAMPLES_AVERAGED(GROUP_SIZE)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [9:0]           acc_sum;
  int                   acc_count;
  logic [7:0]           shown;
  assd_pkg::digit_pos_t next_pos;
  serial_beat_t         pending_bits [$];

  // word typed in for the transaction being offered, if any
  logic         cur_typed;
  logic [15:0]  cur_word;

  int tx_idle_pct;
  int rx_idle_pct;
  int errors;
  int stall_cycles;
  int n_samples;
  int n_ticks;
  int n_bits;
  int n_averages;

  function automatic logic [15:0] display_word(logic [7:0] v, assd_pkg::digit_pos_t p);
    int         digit;
    logic [7:0] sel;
    case (p)
      assd_pkg::POS_TENS: begin
        digit = (int'(v) / 10) % 10;
        sel = 8'hF4;
      end
      assd_pkg::POS_HUNDREDS: begin
        digit = int'(v) / 100;
        sel = 8'hF2;
      end
      default: begin
        digit = int'(v) % 10;
        sel = 8'hF8;
      end
    endcase
    return {SEG_CODE[digit], sel};
  endfunction

  // output ready, re-rolled every cycle
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    logic         in_fire;
    logic         out_fire;
    logic [15:0]  word;
    serial_beat_t beat;
    serial_beat_t want;
    if (!rst) begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire) begin
        if (in_ch.mode == MODE_SAMPLE) begin
          n_samples++;
          acc_sum = acc_sum + 10'(in_ch.sample);
          acc_count++;
          if (acc_count >= GROUP_SIZE) begin
            shown = 8'(acc_sum / GROUP_SIZE);
            acc_sum = '0;
            acc_count = 0;
            n_averages++;
          end
        end else begin
          n_ticks++;
          word = cur_typed ? cur_word : display_word(shown, next_pos);
          for (int k = 0; k < BITS_PER_TICK; k++) begin
            beat.serial_bit = word[BITS_PER_TICK-1-k];
            beat.latch_after = (k == BITS_PER_TICK - 1);
            beat.digit_position = next_pos;
            pending_bits.push_back(beat);
          end
          next_pos = (next_pos == assd_pkg::POS_HUNDREDS) ?
                     assd_pkg::POS_ONES : assd_pkg::digit_pos_t'(next_pos + 1);
        end
      end
      if (out_fire) begin
        n_bits++;
        if (pending_bits.size() == 0) begin
          $error("unexpected output transaction: serial_bit=%0b latch_after=%0b pos=%0d",
                 out_ch.serial_bit, out_ch.latch_after, out_ch.digit_position);
          errors++;
        end else begin
          want = pending_bits.pop_front();
          if (out_ch.serial_bit !== want.serial_bit) begin
            $error("serial_bit: expected %0b, got %0b", want.serial_bit, out_ch.serial_bit);
            errors++;
          end
          if (out_ch.latch_after !== want.latch_after) begin
            $error("latch_after: expected %0b, got %0b", want.latch_after, out_ch.latch_after);
            errors++;
          end
          if (out_ch.digit_position !== want.digit_position) begin
            $error("digit_position: expected %0d, got %0d",
                   want.digit_position, out_ch.digit_position);
            errors++;
          end
        end
      end
      if (in_fire || out_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // offer one item, called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic mode, logic [7:0] sample, logic typed, logic [15:0] word);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.sample <= sample;
    cur_typed = typed;
    cur_word = word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // sender holds off until the display has shifted out everything owed
  task automatic drain_display;
    in_ch.valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly whole groups of close samples followed by ticks, some loose noise
  task automatic random_phase(int target);
    int sent;
    int base;
    int s;
    int n_tk;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 75) begin
        base = $urandom_range(0, 255);
        repeat (GROUP_SIZE) begin
          s = base + $urandom_range(0, 8) - 4;
          if (s < 0) s = 0;
          if (s > 255) s = 255;
          send_item(MODE_SAMPLE, 8'(s), 1'b0, '0);
          sent++;
        end
        n_tk = $urandom_range(1, 4);
        repeat (n_tk) begin
          send_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
          sent++;
        end
      end else begin
        send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    acc_sum = '0;
    acc_count = 0;
    shown = '0;
    next_pos = assd_pkg::POS_ONES;
    cur_typed = 1'b0;
    cur_word = '0;
    errors = 0;
    stall_cycles = 0;
    n_samples = 0;
    n_ticks = 0;
    n_bits = 0;
    n_averages = 0;
    tx_idle_pct = 32;
    rx_idle_pct = 84;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].mode, DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].word);
    end
    random_phase(RANDOM_PER_PHASE - DIR_ROWS);
    drain_display();

    tx_idle_pct = 84;
    rx_idle_pct = 32;
    random_phase(RANDOM_PER_PHASE);
    drain_display();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(RANDOM_PER_PHASE);
    drain_display();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d samples (%0d averages) and %0d refresh ticks, %0d serial bits",
             n_samples, n_averages, n_ticks, n_bits);
    $display("three idling patterns, display drained to empty between them");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
